// ===== rtl/lzssbd_pkg.sv =====
// shared types and constants of the lzss bit-stream decompressor
`timescale 1ns / 1ps
`default_nettype none

package lzssbd_pkg;

   localparam int DICT_DEPTH_DEF = 8192;
   localparam int BYTE_W         = 8;
   localparam int LIMIT_W        = 24;
   localparam int LEN_BITS       = 4;
   localparam int LEN_BIAS       = 3;
   localparam int COPY_LEFT_W    = 5;
   localparam int BITS_LEFT_W    = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

   typedef enum logic [1:0] {
      TOK_NONE,
      TOK_LIT,
      TOK_END,
      TOK_COPY
   } tok_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_LIT,
      ST_END,
      ST_READ,
      ST_COPY,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic rd;
      logic put;
      logic put_copy;
      logic put_done;
      logic flush;
   } cmd_type;

   typedef struct packed {
      tok_type tok;
      logic    finished;
      logic    limit_hit;
      logic    no_bits;
      logic    last_bit;
      logic    copy_last;
      logic    hold_valid;
      logic    can_push;
      logic    out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/lzssbd_ctrl.sv =====
// controller state machine of the lzss bit-stream decompressor
`timescale 1ns / 1ps
`default_nettype none

module lzssbd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire lzssbd_pkg::stat_type stat,
   output lzssbd_pkg::cmd_type       cmd
);
   import lzssbd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_BIT;
            end
         end
         ST_BIT: begin
            if (stat.finished) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.shift = 1'b1;
               unique case (stat.tok)
                  TOK_LIT:  state_in = ST_LIT;
                  TOK_END:  state_in = ST_END;
                  TOK_COPY: state_in = ST_READ;
                  TOK_NONE: state_in = stat.last_bit ? ST_FLUSH : ST_BIT;
                  default:  state_in = ST_FLUSH;
               endcase
            end
         end
         ST_LIT: begin
            if (stat.can_push) begin
               cmd.put = 1'b1;
               state_in = (stat.limit_hit || stat.no_bits) ? ST_FLUSH : ST_BIT;
            end
         end
         ST_END: begin
            if (stat.can_push) begin
               cmd.put_done = 1'b1;
               state_in     = ST_FLUSH;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (stat.can_push) begin
               cmd.put      = 1'b1;
               cmd.put_copy = 1'b1;
               priority if (stat.limit_hit) begin
                  state_in = ST_FLUSH;
               end else if (stat.copy_last) begin
                  state_in = stat.no_bits ? ST_FLUSH : ST_BIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!stat.hold_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/lzssbd_dpath.sv =====
// datapath: bit parser, history ring, counters and result registers
`timescale 1ns / 1ps
`default_nettype none

module lzssbd_dpath #(
   parameter int DICT_DEPTH = lzssbd_pkg::DICT_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [lzssbd_pkg::BYTE_W-1:0]   req_tdata,
   input  wire logic                            req_tuser,
   output logic [lzssbd_pkg::BYTE_W-1:0]        rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lzssbd_pkg::LIMIT_W-1:0]  csr_data,
   input  wire lzssbd_pkg::cmd_type             cmd,
   output lzssbd_pkg::stat_type                 stat
);
   import lzssbd_pkg::*;

   localparam int AW     = $clog2(DICT_DEPTH);
   localparam int PEND_W = 1 + AW + LEN_BITS;
   localparam int CNT_W  = $clog2(PEND_W + 1);

   localparam logic [CNT_W-1:0] CNT_LIT  = CNT_W'(BYTE_W + 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(AW + 1);
   localparam logic [CNT_W-1:0] CNT_COPY = CNT_W'(PEND_W);

   // history ring
   logic [BYTE_W-1:0] ring [DICT_DEPTH];

   logic [LIMIT_W-1:0]     limit_ff;
   logic [BYTE_W-1:0]      byte_ff;
   logic [BITS_LEFT_W-1:0] bits_left_ff;
   logic [PEND_W-1:0]      pend_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   flag_ff;
   logic [BYTE_W-1:0]      lit_ff;
   logic [AW-1:0]          copy_pos_ff;
   logic [COPY_LEFT_W-1:0] copy_left_ff;
   logic [AW-1:0]          wp_ff;
   logic [AW:0]            fill_ff;
   logic [LIMIT_W-1:0]     emitted_ff;
   logic                   finished_ff;
   logic [BYTE_W-1:0]      rd_data_ff;
   logic                   rd_written_ff;
   logic                   hold_valid_ff;
   logic [BYTE_W-1:0]      hold_byte_ff;
   logic                   hold_done_ff;
   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      rsp_byte_ff;
   logic                   rsp_last_ff;
   logic                   rsp_done_ff;

   logic                   in_bit;
   logic                   flag_now;
   logic [PEND_W-1:0]      bits_in;
   logic [CNT_W-1:0]       cnt_in;
   tok_type                tok;
   logic                   limit_hit;
   logic                   out_free;
   logic [AW-1:0]          rd_off;
   logic                   rd_written;
   logic [BYTE_W-1:0]      put_val;
   logic                   res_done;
   logic [BYTE_W-1:0]      res_byte;
   logic                   push;
   logic                   ring_wr;

   // token decode on the incoming bit
   assign in_bit   = byte_ff[BYTE_W-1];
   assign flag_now = (cnt_ff == '0) ? in_bit : flag_ff;
   assign bits_in  = {pend_ff[PEND_W-2:0], in_bit};
   assign cnt_in   = cnt_ff + CNT_W'(1);

   always_comb begin
      priority if (flag_now && cnt_in == CNT_LIT) begin
         tok = TOK_LIT;
      end else if (!flag_now && cnt_in == CNT_END && bits_in[AW-1:0] == '0) begin
         tok = TOK_END;
      end else if (!flag_now && cnt_in == CNT_COPY) begin
         tok = TOK_COPY;
      end else begin
         tok = TOK_NONE;
      end
   end

   // ring entries 1, 2, ... are written in order; fill count marks them
   assign rd_off     = copy_pos_ff - AW'(1);
   assign rd_written = fill_ff[AW] | (rd_off < fill_ff[AW-1:0]);

   assign limit_hit = (emitted_ff >= limit_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign put_val   = cmd.put_copy ? (rd_written_ff ? rd_data_ff : '0) : lit_ff;
   assign res_done  = cmd.put_done || limit_hit;
   assign res_byte  = res_done ? '0 : put_val;
   assign push      = cmd.put || cmd.put_done;
   assign ring_wr   = cmd.put && !limit_hit;

   always_comb begin
      stat            = '0;
      stat.tok        = tok;
      stat.finished   = finished_ff;
      stat.limit_hit  = limit_hit;
      stat.no_bits    = (bits_left_ff == '0);
      stat.last_bit   = (bits_left_ff == BITS_LEFT_W'(1));
      stat.copy_last  = (copy_left_ff == COPY_LEFT_W'(1));
      stat.hold_valid = hold_valid_ff;
      stat.can_push   = !hold_valid_ff || out_free;
      stat.out_free   = out_free;
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring[wp_ff] <= res_byte;
      end
      if (cmd.rd) begin
         rd_data_ff <= ring[copy_pos_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         pend_ff       <= '0;
         cnt_ff        <= '0;
         wp_ff         <= AW'(1);
         fill_ff       <= '0;
         emitted_ff    <= '0;
         finished_ff   <= 1'b0;
         bits_left_ff  <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (cmd.accept) begin
            bits_left_ff <= BITS_LEFT_W'(BYTE_W);
            if (req_tuser) begin
               pend_ff     <= '0;
               cnt_ff      <= '0;
               wp_ff       <= AW'(1);
               fill_ff     <= '0;
               emitted_ff  <= '0;
               finished_ff <= 1'b0;
            end
         end
         if (cmd.shift) begin
            bits_left_ff <= bits_left_ff - BITS_LEFT_W'(1);
            if (tok == TOK_NONE) begin
               pend_ff <= bits_in;
               cnt_ff  <= cnt_in;
            end else begin
               pend_ff <= '0;
               cnt_ff  <= '0;
            end
         end
         if (ring_wr) begin
            wp_ff      <= wp_ff + AW'(1);
            emitted_ff <= emitted_ff + LIMIT_W'(1);
            if (!fill_ff[AW]) begin
               fill_ff <= fill_ff + (AW+1)'(1);
            end
         end
         if (push && res_done) begin
            finished_ff <= 1'b1;
         end
         if (push) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
         if ((push && hold_valid_ff) || cmd.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_tdata;
      end else if (cmd.shift) begin
         byte_ff <= {byte_ff[BYTE_W-2:0], 1'b0};
      end
      if (cmd.shift && cnt_ff == '0) begin
         flag_ff <= in_bit;
      end
      if (cmd.shift && tok == TOK_LIT) begin
         lit_ff <= bits_in[BYTE_W-1:0];
      end
      if (cmd.shift && tok == TOK_COPY) begin
         copy_pos_ff  <= bits_in[AW+LEN_BITS-1:LEN_BITS];
         copy_left_ff <= COPY_LEFT_W'(bits_in[LEN_BITS-1:0]) + COPY_LEFT_W'(LEN_BIAS);
      end else if (cmd.put_copy) begin
         copy_pos_ff  <= copy_pos_ff + AW'(1);
         copy_left_ff <= copy_left_ff - COPY_LEFT_W'(1);
      end
      if (cmd.rd) begin
         rd_written_ff <= rd_written;
      end
      if (push) begin
         hold_byte_ff <= res_byte;
         hold_done_ff <= res_done;
      end
      if (push && hold_valid_ff) begin
         rsp_byte_ff <= hold_byte_ff;
         rsp_done_ff <= hold_done_ff;
         rsp_last_ff <= 1'b0;
      end else if (cmd.flush) begin
         rsp_byte_ff <= hold_byte_ff;
         rsp_done_ff <= hold_done_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/lzss_bitstream_decompressor.sv =====
// top level of the lzss bit-stream decompressor
//
//  channel  direction  payload
//  req_     in         tdata = comp_byte, tuser = first_of_stream
//  rsp_     out        tdata = out_byte, tlast = last_of_run, tuser = stream_done
//  csr_     in         data = output_limit (24 bit)
//
// one compressed byte passes through an accept step, a bit step for each of its
// bits and a flush step; each literal and the end marker add an output step, and
// each copied byte adds a read step and an output step, the read being the
// registered read of the 8 KiB ring; a stop at the end marker or the limit skips
// the remaining bits, and a byte that arrives after the end is not parsed
// the last result of a byte is held back until the byte is parsed, so tlast
// can be marked; the next byte is accepted once that result has moved into
// the output register
// sync reset clears all control state; a restart clears the ring logically
// through a fill count, so no clearing pass is needed
// a stalled rsp_ side stops parsing only when a new result has nowhere to go
`timescale 1ns / 1ps
`default_nettype none

module lzss_bitstream_decompressor #(
   parameter int DICT_DEPTH = lzssbd_pkg::DICT_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // compressed stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [lzssbd_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] comp_byte
   input  wire logic                            req_tuser,   // [0] first_of_stream
   // decompressed stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [lzssbd_pkg::BYTE_W-1:0]        rsp_tdata,   // [7:0] out_byte
   output logic                                 rsp_tlast,   // last_of_run
   output logic                                 rsp_tuser,   // [0] stream_done
   // output limit register
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lzssbd_pkg::LIMIT_W-1:0]  csr_data
);
   import lzssbd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: byte accept, bit by bit parse, literal and copy output
   lzssbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // token parser, history ring, counters and result staging
   lzssbd_dpath #(
      .DICT_DEPTH (DICT_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire
